// ===== src/srcs_pkg.sv =====
// shared types and constants for the sensor range calibration sequencer
// used by the item interface, the controller, the datapath and the top level

package srcs_pkg;

  // default number of sensors tracked
  localparam int SENSOR_COUNT = 8;

  // converter bits kept from a sample
  localparam int SAMPLE_BITS = 10;
  localparam int SAMPLE_W    = 10;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  // tracker start values
  localparam logic [SAMPLE_W-1:0] TRACK_LOW_INIT  = 10'd1020;
  localparam logic [SAMPLE_W-1:0] TRACK_HIGH_INIT = 10'd0;

  // step counters saturate at all ones
  localparam int STEP_W = 9;
  localparam logic [STEP_W-1:0] STEP_MAX = 9'd511;

  // configuration reset values
  localparam logic [11:0] LEFT_DUTY_RST   = 12'd800;
  localparam logic [11:0] RIGHT_DUTY_RST  = 12'd825;
  localparam logic [7:0]  MOVE_STEPS_RST  = 8'd3;
  localparam logic [15:0] PAUSE_TICKS_RST = 16'd5;

  // request codes
  typedef enum logic [2:0] {
    REQ_START  = 3'd0,
    REQ_SAMPLE = 3'd1,
    REQ_LSTEP  = 3'd2,
    REQ_RSTEP  = 3'd3,
    REQ_TICK   = 3'd4
  } req_code_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LEFT_DUTY   = 2'd0,
    CFG_RIGHT_DUTY  = 2'd1,
    CFG_MOVE_STEPS  = 2'd2,
    CFG_PAUSE_TICKS = 2'd3
  } cfg_index_t;

  // phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_MOVE1 = 3'd1;
  localparam logic [2:0] PH_MOVE2 = 3'd2;
  localparam logic [2:0] PH_MOVE3 = 3'd3;
  localparam logic [2:0] PH_PAUSE = 3'd4;

  // input item
  typedef struct packed {
    logic [2:0]          req_type;
    logic [3:0]          sensor_index;
    logic [SAMPLE_W-1:0] sample_value;
  } req_t;

  // result item
  typedef struct packed {
    logic [11:0]         left_level;
    logic                left_reverse;
    logic [11:0]         right_level;
    logic                right_reverse;
    logic [3:0]          lamps;
    logic [2:0]          phase;
    logic                finished;
    logic [3:0]          limit_index;
    logic [SAMPLE_W-1:0] limit_low;
    logic [SAMPLE_W-1:0] limit_high;
    logic                last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       advance;
    logic       pause;
    logic       emit_status;
    logic       emit_limit;
    logic       limit_last;
    logic [3:0] limit_sel;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic accepted;
    logic expired;
    logic goal_met;
    logic pause_zero;
    logic last_is_3;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== src/srcs_stream_if.sv =====
// valid/ready item channel carrying one payload of type T
// depends on srcs_pkg for the default payload type

interface srcs_stream_if #(parameter type T = srcs_pkg::req_t);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/srcs_ctrl.sv =====
// sequencing state machine: accept, settle move boundaries, emit results
// depends on srcs_pkg for the command and status structs

module srcs_ctrl #(
  parameter int SENSOR_COUNT = srcs_pkg::SENSOR_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  srcs_pkg::dp_sts_t     sts,
  output srcs_pkg::ctrl_cmd_t   cmd
);

  localparam int IW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam logic [IW-1:0] LAST_SEL = IW'(SENSOR_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STATUS,
    ST_LIMITS
  } state_t;

  state_t        state, state_next;
  logic [IW-1:0] sel, sel_next;

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    sel_next   = sel;
    cmd.limit_sel = 4'(sel);
    unique case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (sts.accepted) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (sts.expired) begin
          cmd.advance = 1'b1;
          if (sts.last_is_3) begin
            state_next = ST_LIMITS;
            sel_next   = '0;
          end
        end else if (sts.goal_met) begin
          if (!sts.pause_zero) begin
            cmd.pause  = 1'b1;
            state_next = ST_STATUS;
          end else begin
            cmd.advance = 1'b1;
            if (sts.last_is_3) begin
              state_next = ST_LIMITS;
              sel_next   = '0;
            end
          end
        end else begin
          state_next = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_LIMITS: begin
        cmd.limit_last = (sel == LAST_SEL);
        if (sts.out_free) begin
          cmd.emit_limit = 1'b1;
          if (sel == LAST_SEL) begin
            state_next = ST_IDLE;
          end else begin
            sel_next = sel + 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and readout counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= '0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

endmodule

// ===== src/srcs_datapath.sv =====
// move counters, pause timer, per-sensor range trackers, config and result register
// depends on srcs_pkg and srcs_stream_if

module srcs_datapath #(
  parameter int SENSOR_COUNT = srcs_pkg::SENSOR_COUNT
) (
  input  logic                 clk,
  input  logic                 rst,
  srcs_stream_if.sink          req,
  srcs_stream_if.source        res,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  srcs_pkg::ctrl_cmd_t  cmd,
  output srcs_pkg::dp_sts_t    sts
);

  localparam int IW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int SW = srcs_pkg::SAMPLE_W;
  localparam int TW = srcs_pkg::STEP_W;

  // configuration
  logic [11:0] left_duty, right_duty;
  logic [7:0]  move_steps;
  logic [15:0] pause_ticks;

  // sequencing state
  logic [2:0]    move_phase, last_move;
  logic [TW-1:0] left_steps, right_steps;
  logic [15:0]   pause_count;
  logic          expired;

  // trackers
  logic [SW-1:0]           lowest [SENSOR_COUNT];
  logic [SW-1:0]           second_lowest [SENSOR_COUNT];
  logic [SW-1:0]           highest [SENSOR_COUNT];
  logic [SW-1:0]           second_highest [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] trk_valid;

  srcs_pkg::req_t  item;
  srcs_pkg::res_t  out_next;
  logic            accepted, moving, idx_ok, do_track;
  logic [TW-1:0]   goal;
  logic            left_run, right_run;
  logic [SW-1:0]   val;
  logic [IW-1:0]   rd_addr;
  logic [SW-1:0]   rd_lo, rd_lo2, rd_hi, rd_hi2;
  logic [SW-1:0]   wr_lo, wr_lo2, wr_hi, wr_hi2;
  logic [15:0]     pc_dec;

  assign item      = req.data;
  assign req.ready = cmd.take;
  assign accepted  = cmd.take & req.valid;
  assign val       = item.sample_value & srcs_pkg::SAMPLE_MASK;

  // move goal and wheel activity
  assign moving = (move_phase == srcs_pkg::PH_MOVE1) || (move_phase == srcs_pkg::PH_MOVE2) ||
                  (move_phase == srcs_pkg::PH_MOVE3);
  assign goal = (last_move == srcs_pkg::PH_MOVE2) ? TW'({move_steps, 1'b0})
                                                  : TW'(move_steps);
  assign left_run  = left_steps < goal;
  assign right_run = right_steps < goal;

  // status towards the controller
  assign sts.accepted   = accepted;
  assign sts.expired    = expired;
  assign sts.goal_met   = moving && !left_run && !right_run;
  assign sts.pause_zero = (pause_ticks == '0);
  assign sts.last_is_3  = (last_move == srcs_pkg::PH_MOVE3);
  assign sts.out_free   = !res.valid || res.ready;

  // tracker read port: input sensor while taking an item, readout sensor otherwise
  assign rd_addr = cmd.take ? item.sensor_index[IW-1:0] : cmd.limit_sel[IW-1:0];
  assign rd_lo   = trk_valid[rd_addr] ? lowest[rd_addr]         : srcs_pkg::TRACK_LOW_INIT;
  assign rd_lo2  = trk_valid[rd_addr] ? second_lowest[rd_addr]  : srcs_pkg::TRACK_LOW_INIT;
  assign rd_hi   = trk_valid[rd_addr] ? highest[rd_addr]        : srcs_pkg::TRACK_HIGH_INIT;
  assign rd_hi2  = trk_valid[rd_addr] ? second_highest[rd_addr] : srcs_pkg::TRACK_HIGH_INIT;

  assign idx_ok   = {1'b0, item.sensor_index} < 5'(SENSOR_COUNT);
  assign do_track = accepted && (item.req_type == srcs_pkg::REQ_SAMPLE) && moving && idx_ok;

  // two lowest and two highest update
  always_comb begin
    wr_lo  = rd_lo;
    wr_lo2 = rd_lo2;
    wr_hi  = rd_hi;
    wr_hi2 = rd_hi2;
    if (rd_lo2 > val) begin
      if (rd_lo > val) begin
        wr_lo2 = rd_lo;
        wr_lo  = val;
      end else begin
        wr_lo2 = val;
      end
    end
    if (rd_hi2 < val) begin
      if (rd_hi < val) begin
        wr_hi2 = rd_hi;
        wr_hi  = val;
      end else begin
        wr_hi2 = val;
      end
    end
  end

  assign pc_dec = (pause_count != '0) ? pause_count - 1'b1 : pause_count;

  // result contents from the current state
  always_comb begin
    out_next = '0;
    if (moving) begin
      out_next.left_level  = left_run ? left_duty : '0;
      out_next.right_level = right_run ? right_duty : '0;
      if (move_phase == srcs_pkg::PH_MOVE2) begin
        out_next.lamps = {1'b0, left_run, right_run, 1'b0};
      end else begin
        out_next.lamps = {right_run, 2'b00, left_run};
      end
    end
    out_next.left_reverse  = (last_move == srcs_pkg::PH_MOVE2);
    out_next.right_reverse = (last_move != srcs_pkg::PH_MOVE2) && (last_move != srcs_pkg::PH_IDLE);
    out_next.phase         = move_phase;
    if (cmd.emit_limit) begin
      out_next.finished    = 1'b1;
      out_next.limit_index = cmd.limit_sel;
      out_next.limit_low   = rd_lo2;
      out_next.limit_high  = rd_hi2;
      out_next.last        = cmd.limit_last;
    end else begin
      out_next.last = 1'b1;
    end
  end

  // control state, config and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      left_duty   <= srcs_pkg::LEFT_DUTY_RST;
      right_duty  <= srcs_pkg::RIGHT_DUTY_RST;
      move_steps  <= srcs_pkg::MOVE_STEPS_RST;
      pause_ticks <= srcs_pkg::PAUSE_TICKS_RST;
      move_phase  <= srcs_pkg::PH_IDLE;
      last_move   <= srcs_pkg::PH_IDLE;
      left_steps  <= '0;
      right_steps <= '0;
      pause_count <= '0;
      expired     <= 1'b0;
      trk_valid   <= '0;
      res.valid   <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          srcs_pkg::CFG_LEFT_DUTY:   left_duty   <= cfg_data[11:0];
          srcs_pkg::CFG_RIGHT_DUTY:  right_duty  <= cfg_data[11:0];
          srcs_pkg::CFG_MOVE_STEPS:  move_steps  <= cfg_data[7:0];
          srcs_pkg::CFG_PAUSE_TICKS: pause_ticks <= cfg_data;
        endcase
      end
      // item effects
      if (accepted) begin
        case (item.req_type)
          srcs_pkg::REQ_START: begin
            trk_valid   <= '0;
            last_move   <= srcs_pkg::PH_MOVE1;
            move_phase  <= srcs_pkg::PH_MOVE1;
            left_steps  <= '0;
            right_steps <= '0;
            pause_count <= '0;
            expired     <= 1'b0;
          end
          srcs_pkg::REQ_SAMPLE: begin
            if (do_track) begin
              trk_valid[rd_addr] <= 1'b1;
            end
          end
          srcs_pkg::REQ_LSTEP: begin
            if (moving && left_steps != srcs_pkg::STEP_MAX) begin
              left_steps <= left_steps + 1'b1;
            end
          end
          srcs_pkg::REQ_RSTEP: begin
            if (moving && right_steps != srcs_pkg::STEP_MAX) begin
              right_steps <= right_steps + 1'b1;
            end
          end
          srcs_pkg::REQ_TICK: begin
            if (move_phase == srcs_pkg::PH_PAUSE) begin
              pause_count <= pc_dec;
              expired     <= (pc_dec == '0);
            end
          end
          default: ;
        endcase
      end
      // move boundary: next move or end of run
      if (cmd.advance) begin
        left_steps  <= '0;
        right_steps <= '0;
        expired     <= 1'b0;
        if (last_move != srcs_pkg::PH_MOVE3) begin
          last_move  <= last_move + 1'b1;
          move_phase <= last_move + 1'b1;
        end else begin
          move_phase <= srcs_pkg::PH_IDLE;
        end
      end
      // goal reached with a pause to wait
      if (cmd.pause) begin
        move_phase  <= srcs_pkg::PH_PAUSE;
        pause_count <= pause_ticks;
        left_steps  <= '0;
        right_steps <= '0;
      end
      // output register handshake
      if (cmd.emit_status || cmd.emit_limit) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.emit_status || cmd.emit_limit) begin
      res.data <= out_next;
    end
  end

  // tracker storage
  always_ff @(posedge clk) begin
    if (do_track) begin
      lowest[rd_addr]         <= wr_lo;
      second_lowest[rd_addr]  <= wr_lo2;
      highest[rd_addr]        <= wr_hi;
      second_highest[rd_addr] <= wr_hi2;
    end
  end

endmodule

// ===== src/sensor_range_calibration_sequencer.sv =====
// an item is taken in the idle state, settled in the check state one move boundary at
// a time, and its result loaded into the output register from the status state
// a new item is taken only after the result of the last one is loaded; the item ending
// the third move gives SENSOR_COUNT results from the tracker port, one per cycle while the output is free
// reset: synchronous rst returns to idle, restores config defaults and marks all
// trackers unwritten so they read as their start values

module sensor_range_calibration_sequencer #(
  parameter int SENSOR_COUNT = srcs_pkg::SENSOR_COUNT
) (
  input  logic          clk,
  input  logic          rst,
  srcs_stream_if.sink   req,
  srcs_stream_if.source res,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  srcs_pkg::ctrl_cmd_t cmd;
  srcs_pkg::dp_sts_t   sts;

  // sequencing controller
  srcs_ctrl #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // counters, trackers and result register
  srcs_datapath #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
